### src/sq4dd_pkg.sv
// ============================================================================
// sq4dd_pkg
// Shared widths, constants, codes and helpers of the 4-bit scalar
// quantization distance unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sq4dd_pkg;

    // fixed point
    localparam int FRAC_BITS   = 16;
    localparam int SHIFT       = 32 - 2 * FRAC_BITS;
    localparam int SHIFT_L     = (SHIFT > 0) ? SHIFT : 0;
    localparam int SHIFT_R     = (SHIFT < 0) ? -SHIFT : 0;

    // field widths
    localparam int CODE_W      = 4;
    localparam int BYTE_W      = 2 * CODE_W;
    localparam int VALUE_W     = 32;
    localparam int RANGE_W     = 31;
    localparam int DIST_W      = 64;

    // division of the range by 15 through a reciprocal
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP15 = 32'd2290649225;
    localparam int RECIP_SHIFT = 35;
    localparam int RPROD_W     = RANGE_W + RECIP_W;
    localparam int Q_W         = RPROD_W - RECIP_SHIFT;
    localparam int CQ_W        = Q_W + CODE_W;

    // datapath widths
    localparam int DQ_W        = 34;
    localparam int OP_W        = DQ_W + 1;
    localparam int PL_W        = 16;
    localparam int PH_W        = OP_W - PL_W;
    localparam int HH_W        = 2 * PH_W;
    localparam int HL_W        = PH_W + PL_W + 1;
    localparam int LL_W        = 2 * (PL_W + 1);
    localparam int TERM_W      = 2 * OP_W;
    localparam int SUM_W       = TERM_W + 1;
    localparam int SH_W        = SUM_W + SHIFT_L;
    localparam int ACC_W       = SH_W + 1;

    localparam int LANE_STAGES = 6;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_METRIC = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE = 4'd1;

    typedef enum logic {
        METRIC_IP = 1'b0,
        METRIC_L2 = 1'b1
    } metric_t;

    typedef enum logic {
        SRC_QUERY = 1'b0,
        SRC_CODES = 1'b1
    } source_t;

    typedef struct packed {
        logic    adv;
        source_t source;
        metric_t metric;
    } lane_ctrl_t;

    typedef struct packed {
        logic adv;
        logic valid;
        logic last;
    } merge_ctrl_t;

    // floor(p / 15) for p below 240: 137 / 2048 is close enough to 1/15
    function automatic logic [CODE_W-1:0] div15_small(input logic [BYTE_W-1:0] p);
        logic [15:0] t;
        t = 16'(p) * 16'd137;
        return t[14:11];
    endfunction

endpackage

`default_nettype wire

### src/sq4dd_lane.sv
// ============================================================================
// sq4dd_lane
// One dimension: dequantizes the code (and the second code), forms the
// operands and produces the exact product or square term.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sq4dd_lane
    import sq4dd_pkg::*;
(
    input  wire                      clk,
    input  lane_ctrl_t               ctrl,
    input  wire  [CODE_W-1:0]        code,
    input  wire  [CODE_W-1:0]        other_code,
    input  wire  signed [VALUE_W-1:0] query,
    input  wire  signed [VALUE_W-1:0] lower,
    input  wire  [RANGE_W-1:0]       rng,
    output logic signed [TERM_W-1:0] term
);

    // stage 1: range / 15
    logic [Q_W-1:0]            q_reg;
    logic [CODE_W-1:0]         rng_lo_reg;
    logic [CODE_W-1:0]         code1_reg, ocode1_reg;
    logic signed [VALUE_W-1:0] query1_reg, lower1_reg;
    logic [RPROD_W-1:0]        rprod;

    // stage 2: code * quotient and the remainder fraction
    logic [CQ_W-1:0]           cq_y_reg, cq_x_reg;
    logic [CODE_W-1:0]         f_y_reg, f_x_reg;
    logic signed [VALUE_W-1:0] query2_reg, lower2_reg;
    logic [CODE_W-1:0]         rem;

    // stage 3: dequantized values
    logic signed [DQ_W-1:0]    x_reg, y_reg;
    logic signed [DQ_W-1:0]    x_next, y_next, x_code;

    // stage 4: multiplier operands
    logic signed [OP_W-1:0]    a_reg, b_reg;
    logic signed [OP_W-1:0]    a_next, b_next, diff;

    // stage 5: partial products
    logic signed [HH_W-1:0]    pp_hh_reg;
    logic signed [HL_W-1:0]    pp_hl_reg, pp_lh_reg;
    logic signed [LL_W-1:0]    pp_ll_reg;
    logic signed [PH_W-1:0]    a_hi, b_hi;
    logic signed [PL_W:0]      a_lo, b_lo;

    // stage 6: term
    logic signed [TERM_W-1:0]  term_reg;
    logic signed [TERM_W-1:0]  term_next;

    assign rprod = RPROD_W'(rng) * RPROD_W'(RECIP15);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            q_reg      <= rprod[RPROD_W-1:RECIP_SHIFT];
            rng_lo_reg <= rng[CODE_W-1:0];
            code1_reg  <= code;
            ocode1_reg <= other_code;
            query1_reg <= query;
            lower1_reg <= lower;
        end
    end

    // remainder only needs its low nibble
    assign rem = rng_lo_reg - CODE_W'(q_reg[CODE_W-1:0] * 4'd15);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            cq_y_reg   <= CQ_W'(code1_reg) * CQ_W'(q_reg);
            cq_x_reg   <= CQ_W'(ocode1_reg) * CQ_W'(q_reg);
            f_y_reg    <= div15_small(BYTE_W'(code1_reg) * BYTE_W'(rem));
            f_x_reg    <= div15_small(BYTE_W'(ocode1_reg) * BYTE_W'(rem));
            query2_reg <= query1_reg;
            lower2_reg <= lower1_reg;
        end
    end

    always_comb
    begin
        y_next = DQ_W'(lower2_reg) + DQ_W'($signed({1'b0, cq_y_reg}))
               + DQ_W'($signed({1'b0, f_y_reg}));
        x_code = DQ_W'(lower2_reg) + DQ_W'($signed({1'b0, cq_x_reg}))
               + DQ_W'($signed({1'b0, f_x_reg}));
        unique case (ctrl.source)
            SRC_CODES: x_next = x_code;
            SRC_QUERY: x_next = DQ_W'(query2_reg);
            default:   x_next = DQ_W'(query2_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    always_comb
    begin
        diff = OP_W'(x_reg) - OP_W'(y_reg);
        unique case (ctrl.metric)
            METRIC_L2:
            begin
                a_next = diff;
                b_next = diff;
            end
            METRIC_IP:
            begin
                a_next = OP_W'(x_reg);
                b_next = OP_W'(y_reg);
            end
            default:
            begin
                a_next = OP_W'(x_reg);
                b_next = OP_W'(y_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    // signed high part, unsigned low part
    assign a_hi = a_reg[OP_W-1:PL_W];
    assign b_hi = b_reg[OP_W-1:PL_W];
    assign a_lo = $signed({1'b0, a_reg[PL_W-1:0]});
    assign b_lo = $signed({1'b0, b_reg[PL_W-1:0]});

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            pp_hh_reg <= HH_W'(a_hi) * HH_W'(b_hi);
            pp_hl_reg <= HL_W'(a_hi) * HL_W'(b_lo);
            pp_lh_reg <= HL_W'(a_lo) * HL_W'(b_hi);
            pp_ll_reg <= LL_W'(a_lo) * LL_W'(b_lo);
        end
    end

    assign term_next = (TERM_W'(pp_hh_reg) <<< (2 * PL_W))
                     + (TERM_W'(pp_hl_reg) <<< PL_W)
                     + (TERM_W'(pp_lh_reg) <<< PL_W)
                     + TERM_W'(pp_ll_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

`default_nettype wire

### src/sq4dd_merge.sv
// ============================================================================
// sq4dd_merge
// Adds the two lane terms, scales to 32 fractional bits, accumulates with
// saturation and holds the result word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sq4dd_merge
    import sq4dd_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  merge_ctrl_t              ctrl,
    input  wire  signed [TERM_W-1:0] term_even,
    input  wire  signed [TERM_W-1:0] term_odd,
    output logic                     result_valid,
    output logic signed [DIST_W-1:0] distance,
    output logic                     saturated
);

    logic                     m1_valid_reg, m1_last_reg;
    logic signed [SH_W-1:0]   t_reg;
    logic signed [SUM_W-1:0]  t_sum;
    logic signed [SH_W-1:0]   t_ext, t_next;

    logic signed [DIST_W-1:0] sum_acc_reg, sum_acc_next;
    logic                     sat_seen_reg, sat_seen_next;
    logic                     result_valid_reg, result_valid_next;
    logic signed [DIST_W-1:0] distance_reg, distance_next;
    logic                     saturated_reg, saturated_next;

    logic signed [ACC_W-1:0]  acc;
    logic                     ovf;
    logic signed [DIST_W-1:0] acc_sat;

    always_comb
    begin
        t_sum  = SUM_W'(term_even) + SUM_W'(term_odd);
        t_ext  = SH_W'(t_sum);
        t_next = (t_ext <<< SHIFT_L) >>> SHIFT_R;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
        end
        else if (ctrl.adv)
        begin
            m1_valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            m1_last_reg <= ctrl.last;
            t_reg       <= t_next;
        end
    end

    always_comb
    begin
        acc = ACC_W'(sum_acc_reg) + ACC_W'(t_reg);
        ovf = acc[ACC_W-1:DIST_W-1] != {(ACC_W-DIST_W+1){acc[ACC_W-1]}};
        if (!ovf)
            acc_sat = acc[DIST_W-1:0];
        else if (acc[ACC_W-1])
            acc_sat = {1'b1, {(DIST_W-1){1'b0}}};
        else
            acc_sat = {1'b0, {(DIST_W-1){1'b1}}};

        sum_acc_next      = sum_acc_reg;
        sat_seen_next     = sat_seen_reg;
        result_valid_next = result_valid_reg;
        distance_next     = distance_reg;
        saturated_next    = saturated_reg;

        if (ctrl.adv)
        begin
            result_valid_next = 1'b0;
            if (m1_valid_reg)
            begin
                if (m1_last_reg)
                begin
                    result_valid_next = 1'b1;
                    distance_next     = acc_sat;
                    saturated_next    = sat_seen_reg | ovf;
                    sum_acc_next      = '0;
                    sat_seen_next     = 1'b0;
                end
                else
                begin
                    sum_acc_next  = acc_sat;
                    sat_seen_next = sat_seen_reg | ovf;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_acc_reg      <= '0;
            sat_seen_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sum_acc_reg      <= sum_acc_next;
            sat_seen_reg     <= sat_seen_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg  <= distance_next;
        saturated_reg <= saturated_next;
    end

    assign result_valid = result_valid_reg;
    assign distance     = distance_reg;
    assign saturated    = saturated_reg;

endmodule

`default_nettype wire

### src/sq4_dequant_distance.sv
// ============================================================================
// sq4_dequant_distance
// Streaming 4-bit scalar quantization distance unit, two dimensions a word.
// ============================================================================
// Usage:
//   item channel (item_valid / item_stall): one word per dimension pair,
//   a packed code byte, the second code byte, the query pair and each
//   dimension's lower bound and range. last_pair closes the vector.
//   result channel (result_valid / result_stall): one word per vector,
//   the accumulated inner product or squared L2 distance (Q32.32) and a
//   flag that the sum saturated somewhere in the vector.
//   config channel (cfg_valid / cfg_ready): register index and data,
//   index 0 metric, 1 operand source; cfg_ready is always high and the
//   registers should only change while nothing is in flight.
// Timing:
//   one word accepted per cycle while no result is held under
//   result_stall; both lanes and the merge are fully pipelined, eight
//   register stages deep, and a last word's result passes all of them.
//   the accumulator add with saturation is a loop with no register
//   inside it, which sets the one-word-per-cycle figure.
// Reset clears the pipeline, accumulator and registers; item_stall is high
// during reset. While a result waits under result_stall the whole pipeline
// holds and item_stall is raised.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sq4_dequant_distance
    import sq4dd_pkg::*;
(
    input  wire                         clk,
    input  wire                         rst_n,

    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [CFG_DATA_W-1:0]       cfg_data,

    input  wire                         item_valid,
    output logic                        item_stall,
    input  wire  [BYTE_W-1:0]           code_byte,
    input  wire  [BYTE_W-1:0]           other_code_byte,
    input  wire  signed [VALUE_W-1:0]   query_even,
    input  wire  signed [VALUE_W-1:0]   query_odd,
    input  wire  signed [VALUE_W-1:0]   lower_even,
    input  wire  signed [VALUE_W-1:0]   lower_odd,
    input  wire  [RANGE_W-1:0]          range_even,
    input  wire  [RANGE_W-1:0]          range_odd,
    input  wire                         last_pair,

    output logic                        result_valid,
    input  wire                         result_stall,
    output logic signed [DIST_W-1:0]    distance,
    output logic                        saturated
);

    metric_t                  metric_reg;
    source_t                  source_reg;
    logic                     adv;
    logic [LANE_STAGES-1:0]   valid_pipe_reg;
    logic [LANE_STAGES-1:0]   last_pipe_reg;
    lane_ctrl_t               lane_ctrl;
    merge_ctrl_t              merge_ctrl;
    logic signed [TERM_W-1:0] term_even, term_odd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_IP;
            source_reg <= SRC_QUERY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_METRIC)
                metric_reg <= metric_t'(cfg_data[0]);
            if (cfg_index == REG_SOURCE)
                source_reg <= source_t'(cfg_data[0]);
        end
    end

    // everything moves unless a finished word is held at the output
    assign adv        = !(result_valid && result_stall);
    assign item_stall = !rst_n || !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
        end
        else if (adv)
        begin
            valid_pipe_reg <= {valid_pipe_reg[LANE_STAGES-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_pipe_reg <= {last_pipe_reg[LANE_STAGES-2:0], last_pair};
        end
    end

    assign lane_ctrl.adv    = adv;
    assign lane_ctrl.source = source_reg;
    assign lane_ctrl.metric = metric_reg;

    assign merge_ctrl.adv   = adv;
    assign merge_ctrl.valid = valid_pipe_reg[LANE_STAGES-1];
    assign merge_ctrl.last  = last_pipe_reg[LANE_STAGES-1];

    sq4dd_lane u_lane_even (
        .clk        (clk),
        .ctrl       (lane_ctrl),
        .code       (code_byte[CODE_W-1:0]),
        .other_code (other_code_byte[CODE_W-1:0]),
        .query      (query_even),
        .lower      (lower_even),
        .rng        (range_even),
        .term       (term_even)
    );

    sq4dd_lane u_lane_odd (
        .clk        (clk),
        .ctrl       (lane_ctrl),
        .code       (code_byte[BYTE_W-1:CODE_W]),
        .other_code (other_code_byte[BYTE_W-1:CODE_W]),
        .query      (query_odd),
        .lower      (lower_odd),
        .rng        (range_odd),
        .term       (term_odd)
    );

    sq4dd_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (merge_ctrl),
        .term_even    (term_even),
        .term_odd     (term_odd),
        .result_valid (result_valid),
        .distance     (distance),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire

### src/sq4dd_checker.sv
// ============================================================================
// sq4dd_checker
// Port-level checks of the distance unit, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sq4dd_checker
    import sq4dd_pkg::*;
(
    input wire                      clk,
    input wire                      rst_n,
    input wire                      item_valid,
    input wire                      item_stall,
    input wire                      last_pair,
    input wire                      result_valid,
    input wire                      result_stall,
    input wire signed [DIST_W-1:0]  distance,
    input wire                      saturated
);

    // input side is held back exactly when a finished word is blocked
    a_stall_follows_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_stall == (result_valid && result_stall)
    ) else $error("item_stall does not match a blocked result");

    // a blocked result word holds
    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(distance) && $stable(saturated))
    ) else $error("result word changed while stalled");

    // a last word followed by a free-running pipeline raises result_valid
    a_last_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && last_pair)
            ##1 !item_stall ##1 !item_stall ##1 !item_stall ##1 !item_stall
            ##1 !item_stall ##1 !item_stall ##1 !item_stall
            |=> result_valid
    ) else $error("no result after a last word");

endmodule

bind sq4_dequant_distance sq4dd_checker u_sq4dd_checker (.*);

`default_nettype wire
